/* rtl/core/sud_pkg.sv */
// Package: shared constants, types and the one-bit division step of the divider.
package sud_pkg;

   localparam int unsigned DataWidth   = 64;
   localparam int unsigned NarrowWidth = 32;
   localparam int unsigned NumStages   = DataWidth;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned CountWidth  = $clog2(QueueDepth + 1);

   // op field bits
   localparam int unsigned OpSignedBit = 0;
   localparam int unsigned OpWideBit   = 1;

   // classified work item: dividend magnitude shifts out while quotient bits shift in
   typedef struct packed {
      logic [DataWidth-1:0] qn;
      logic [DataWidth:0]   dv;        // divisor magnitude; 2**64 when dividing by zero
      logic                 neg_q;
      logic                 neg_r;
      logic                 is_signed;
      logic                 is_wide;
   } work_type;

   typedef struct packed {
      logic [DataWidth-1:0] rem;
      work_type             w;
   } stage_type;

   // restoring step: shift in one dividend bit, subtract when it fits
   function automatic stage_type div_step(stage_type s);
      logic [DataWidth:0] r_new;
      logic [DataWidth:0] diff;
      logic               ge;
      stage_type          o;
      r_new  = {s.rem, s.w.qn[DataWidth-1]};
      diff   = r_new - s.w.dv;
      ge     = (r_new >= s.w.dv);
      o      = s;
      o.w.qn = {s.w.qn[DataWidth-2:0], ge};
      o.rem  = ge ? diff[DataWidth-1:0] : r_new[DataWidth-1:0];
      return o;
   endfunction

endpackage

/* rtl/core/sud_if.sv */
// Interfaces: request and response channels of the divider.
interface sud_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] dividend;
   logic [63:0] divisor;
   modport source (output valid, output op, output dividend, output divisor, input ready);
   modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface

interface sud_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] quotient_out;
   logic [63:0] remainder_out;
   modport source (output valid, output quotient_out, output remainder_out, input ready);
   modport sink   (input valid, input quotient_out, input remainder_out, output ready);
endinterface

/* rtl/core/signed_unsigned_integer_divider.sv */
// Path: a request is written into the queue, passes through the 64 stages in order, and
//   the output register loads at the end of the last stage.
// Throughput: one transaction per cycle while the response is not stalled; a 64-stage restoring
//   pipeline, one quotient bit per stage, takes a new item every cycle unless stalled.
// A stalled response holds the pipeline; the two-entry queue keeps taking requests until full.
// Reset (synchronous, active high) clears queue pointers, stage valid bits and output valid.
module signed_unsigned_integer_divider
   import sud_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sud_req_if.sink   req_if,
   sud_rsp_if.source rsp_if
);

   // front end -> queue
   work_type entry;
   logic     push;
   logic     full;

   // queue -> division pipeline
   work_type head;
   logic     nonempty;
   logic     pop;

   // classify: mask to width, magnitudes, sign flags, divide-by-zero divisor
   sud_front u_front (
      .req_if (req_if),
      .full   (full),
      .push   (push),
      .entry  (entry)
   );

   // decouples request acceptance from pipeline stalls
   sud_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (pop),
      .full      (full),
      .nonempty  (nonempty),
      .head      (head)
   );

   // long division, sign fix-up and response register
   sud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (nonempty),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

/* rtl/core/sud_front.sv */
// Front end: accepts a request, masks operands to width, takes magnitudes and flags.
module sud_front
   import sud_pkg::*;
(
   sud_req_if.sink  req_if,
   input  logic     full,
   output logic     push,
   output work_type entry
);

   logic                 wide, sgn, n_neg, d_neg, dz;
   logic [DataWidth-1:0] n, d, neg_n, neg_d, an, ad;

   always_comb begin
      wide  = req_if.op[OpWideBit];
      sgn   = req_if.op[OpSignedBit];
      n     = wide ? req_if.dividend : {{NarrowWidth{1'b0}}, req_if.dividend[NarrowWidth-1:0]};
      d     = wide ? req_if.divisor  : {{NarrowWidth{1'b0}}, req_if.divisor[NarrowWidth-1:0]};
      n_neg = sgn & (wide ? n[DataWidth-1] : n[NarrowWidth-1]);
      d_neg = sgn & (wide ? d[DataWidth-1] : d[NarrowWidth-1]);
      neg_n = '0 - n;
      neg_d = '0 - d;
      an    = !n_neg ? n : (wide ? neg_n : {{NarrowWidth{1'b0}}, neg_n[NarrowWidth-1:0]});
      ad    = !d_neg ? d : (wide ? neg_d : {{NarrowWidth{1'b0}}, neg_d[NarrowWidth-1:0]});
      dz    = (d == '0);
      entry.qn        = an;
      // divide by zero: a divisor that never fits leaves q = 0, r = |n|
      entry.dv        = dz ? {1'b1, {DataWidth{1'b0}}} : {1'b0, ad};
      entry.neg_q     = n_neg ^ d_neg;
      entry.neg_r     = n_neg;
      entry.is_signed = sgn;
      entry.is_wide   = wide;
   end

   assign req_if.ready = !full;
   assign push         = req_if.valid && !full;

endmodule

/* rtl/core/sud_fifo.sv */
// Short queue between front end and division pipeline.
module sud_fifo
   import sud_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     nonempty,
   output work_type head
);

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   work_type                mem_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign full     = (count_ff == CountWidth'(QueueDepth));
   assign nonempty = (count_ff != '0);
   assign head     = mem_ff[rd_ff];
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth)) else $error("queue count over depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");
`endif

endmodule

/* rtl/core/sud_back.sv */
// Back end: 64-stage restoring division pipeline, sign fix-up and output register.
module sud_back
   import sud_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  work_type head,
   input  logic     head_valid,
   output logic     pop,
   sud_rsp_if.source rsp_if
);

   stage_type            stage_ff [NumStages];
   logic                 valid_ff [NumStages];
   logic                 out_valid_ff;
   logic [DataWidth-1:0] q_ff, q_in, r_ff, r_in;
   logic                 advance;
   stage_type            first, last;
   logic [DataWidth-1:0] qs, rs;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign pop     = advance && head_valid;

   always_comb begin
      first.rem = '0;
      first.w   = head;
   end

   assign last = stage_ff[NumStages-1];

   always_comb begin
      qs = last.w.neg_q ? ('0 - last.w.qn) : last.w.qn;
      rs = last.w.neg_r ? ('0 - last.rem)  : last.rem;
      if (last.w.is_wide) begin
         q_in = qs;
         r_in = rs;
      end else if (last.w.is_signed) begin
         q_in = {{NarrowWidth{qs[NarrowWidth-1]}}, qs[NarrowWidth-1:0]};
         r_in = {{NarrowWidth{rs[NarrowWidth-1]}}, rs[NarrowWidth-1:0]};
      end else begin
         q_in = {{NarrowWidth{1'b0}}, qs[NarrowWidth-1:0]};
         r_in = {{NarrowWidth{1'b0}}, rs[NarrowWidth-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumStages; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= head_valid;
         for (int s = 1; s < NumStages; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[NumStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= div_step(first);
         for (int s = 1; s < NumStages; s++) begin
            stage_ff[s] <= div_step(stage_ff[s-1]);
         end
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.quotient_out  = q_ff;
   assign rsp_if.remainder_out = r_ff;

endmodule

/* tb/sud_tb_if.sv */
// Testbench-side note: interfaces come from the RTL; this file holds shared test types.
`timescale 1ns / 100ps
package sud_tb_pkg;
   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

   localparam logic [1:0] OpUnsigned32 = 2'd0;
   localparam logic [1:0] OpSigned32   = 2'd1;
   localparam logic [1:0] OpUnsigned64 = 2'd2;
   localparam logic [1:0] OpSigned64   = 2'd3;
endpackage

/* tb/signed_unsigned_integer_divider_test.sv */
// Testbench: random and directed signed/unsigned divisions checked against a local predictor.
`timescale 1ns / 100ps
module signed_unsigned_integer_divider_test;
   import sud_pkg::*;
   import sud_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sud_req_if req_if ();
   sud_rsp_if rsp_if ();

   signed_unsigned_integer_divider u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #5 clock = ~clock;

   div_req_type pending_q[$];     // items waiting for the driver
   div_rsp_type quot_rem_q[$];    // expected quotient/remainder, oldest first
   int          errors    = 0;
   int          sent      = 0;
   int          received  = 0;
   int          zero_divs = 0;
   bit          stim_done = 1'b0;

   // Bit-serial restoring division at width w; the carry out of the partial
   // remainder keeps large divisors correct.
   function automatic void long_div(input logic [63:0] n, input logic [63:0] d,
                                    input int w, output logic [63:0] q,
                                    output logic [63:0] r);
      logic [64:0] part;
      q    = '0;
      part = '0;
      for (int i = w - 1; i >= 0; i--) begin
         part = {part[63:0], n[i]};
         if (part >= {1'b0, d}) begin
            part = part - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      r = part[63:0];
   endfunction

   function automatic div_rsp_type predict_div(div_req_type t);
      div_rsp_type res;
      logic        sgn;
      int          w;
      logic [63:0] m, n, d, an, ad, q, r;
      logic        n_neg, d_neg;
      sgn = t.op[OpSignedBit];
      w   = t.op[OpWideBit] ? 64 : 32;
      m   = (w == 64) ? '1 : 64'h0000_0000_FFFF_FFFF;
      n   = t.dividend & m;
      d   = t.divisor & m;
      n_neg = n[w-1];
      d_neg = d[w-1];
      if (d == 0) begin
         // divide by zero: quotient 0, remainder is the dividend
         q = '0;
         r = n;
      end else if (!sgn) begin
         long_div(n, d, w, q, r);
      end else begin
         an = n_neg ? ((~n + 1) & m) : n;
         ad = d_neg ? ((~d + 1) & m) : d;
         long_div(an, ad, w, q, r);
         if (n_neg != d_neg) q = (~q + 1) & m;
         if (n_neg) r = (~r + 1) & m;
      end
      q &= m;
      r &= m;
      if (sgn && w == 32) begin
         if (q[31]) q[63:32] = '1;
         if (r[31]) r[63:32] = '1;
      end
      res.quotient  = q;
      res.remainder = r;
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = v >> $urandom_range(0, 63);      // small magnitudes
         1: v = ~(v >> $urandom_range(0, 63));    // near all-ones / small negatives
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_item(logic [1:0] op, logic [63:0] n, logic [63:0] d);
      div_req_type t;
      t.op       = op;
      t.dividend = n;
      t.divisor  = d;
      pending_q.push_back(t);
   endtask

   // Driver: bursts of transactions with random gaps in between.
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.op       <= OpUnsigned32;
         req_if.dividend <= '0;
         req_if.divisor  <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            quot_rem_q.push_back(predict_div({req_if.op, req_if.dividend, req_if.divisor}));
            sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
               req_if.valid <= 1'b0;
            end else begin
               div_req_type t;
               t = pending_q.pop_front();
               req_if.valid    <= 1'b1;
               req_if.op       <= t.op;
               req_if.dividend <= t.dividend;
               req_if.divisor  <= t.divisor;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Monitor: receiver stalls in its own pattern; each response checked in order.
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            received++;
            if (quot_rem_q.size() == 0) begin
               $display("%0t: unexpected response q=%h r=%h", $time,
                        rsp_if.quotient_out, rsp_if.remainder_out);
               errors++;
            end else begin
               div_rsp_type e;
               e = quot_rem_q.pop_front();
               if (e.quotient !== rsp_if.quotient_out) begin
                  $display("%0t: quotient expected %h actual %h", $time,
                           e.quotient, rsp_if.quotient_out);
                  errors++;
               end
               if (e.remainder !== rsp_if.remainder_out) begin
                  $display("%0t: remainder expected %h actual %h", $time,
                           e.remainder, rsp_if.remainder_out);
                  errors++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 600;
         // long stretch fully ready, then random stalls, then a long hold
         if (stall_phase < 200)      rsp_if.ready <= 1'b1;
         else if (stall_phase < 520) rsp_if.ready <= ($urandom_range(0, 2) != 0);
         else                        rsp_if.ready <= (stall_phase > 580);
      end
   end

   initial begin
      logic [63:0] big, n, d;
      logic [1:0]  op;
      big = 64'h8000_0000_0000_0000;

      // Directed: each operation with extremes and special cases.
      for (int k = 0; k < 4; k++) begin
         op = k[1:0];
         add_item(op, 64'd100, 64'd7);
         add_item(op, '1, 64'd0);                    // divide by zero
         add_item(op, op[OpWideBit] ? big : 64'h8000_0000, '1); // most negative by -1
      end
      add_item(OpSigned64, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);     // -7 / 2
      add_item(OpSigned64, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);     // 7 / -2
      add_item(OpSigned32, 64'hABCD_0000_FFFF_FFF9, 64'h1234_0000_0000_0002);
      add_item(OpUnsigned64, '1, big);                          // divisor with top bit set
      add_item(OpUnsigned64, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_item(OpUnsigned32, 64'h0000_0001_FFFF_FFFF, 64'h8000_0001);
      add_item(OpUnsigned64, '1, 64'd1);
      add_item(OpSigned64, big, 64'd1);
      add_item(OpUnsigned64, 64'd0, '1);

      // Random part.
      for (int i = 0; i < 1100; i++) begin
         op = 2'($urandom_range(0, 3));
         n  = rand64();
         case ($urandom_range(0, 9))
            0: d = 64'd0;
            1: d = '1;
            2: d = 64'd1 << $urandom_range(0, 63);
            default: d = rand64();
         endcase
         if ((d & (op[OpWideBit] ? '1 : 64'hFFFF_FFFF)) == 0) zero_divs++;
         add_item(op, n, d);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0 && !req_if.valid);
      wait (quot_rem_q.size() == 0);
      repeat (80) @(posedge clock);
      $display("Covered %0d divisions (%0d responses), all four op codes,", sent, received);
      $display("  %0d random zero divisors plus directed overflow cases.", zero_divs);
      if (errors == 0 && quot_rem_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule
